// File: design/qcec_pkg.sv
// ----------------------------------------------------------------------------
// qcec_pkg
// shared types and constants for the quadrature counter with edge capture
// ----------------------------------------------------------------------------
package qcec_pkg;

   // item operation codes
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // width of the position and read data ports
   localparam int OUT_WIDTH = 32;
   // width of the fill level ports
   localparam int ENTRIES_WIDTH = 7;
   // width of the read index field
   localparam int INDEX_WIDTH = 6;

   // per-item commands from the tracker to the capture tables
   typedef struct packed {
      logic store_rise;
      logic store_fall;
      logic read_en;
      logic clear;
   } capture_ctrl_type;

endpackage

// File: design/qcec_track.sv
// ----------------------------------------------------------------------------
// qcec_track
// x4 position counter, previous line levels and strobe edge detection
// ----------------------------------------------------------------------------
module qcec_track import qcec_pkg::*; #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [1:0]                  op,
   input  logic                        line_a,
   input  logic                        line_b,
   input  logic                        strobe_line,
   input  logic                        capture_enable,
   output logic signed [OUT_WIDTH-1:0] position,
   output logic [OUT_WIDTH-1:0]        capture_value,
   output logic                        step_error,
   output capture_ctrl_type            ctrl
);

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic prev_a_ff, prev_b_ff, prev_s_ff, primed_ff;
   logic step_error_ff;
   logic is_sample, da, db, move, up, strobe_edge;

   assign is_sample = (op == OP_SAMPLE);
   assign da        = line_a ^ prev_a_ff;
   assign db        = line_b ^ prev_b_ff;
   // exactly one line changed: a legal step
   assign move      = primed_ff && (da ^ db);
   assign up        = da ? (line_a != line_b) : (line_a == line_b);

   always_comb begin
      count_in = count_ff;
      if (is_sample && move) begin
         if (up) begin
            count_in = count_ff + COUNT_WIDTH'(1);
         end else begin
            count_in = count_ff - COUNT_WIDTH'(1);
         end
      end
   end

   assign strobe_edge = is_sample && primed_ff && capture_enable &&
                        (strobe_line != prev_s_ff);

   always_comb begin
      ctrl.store_rise = advance && strobe_edge && strobe_line;
      ctrl.store_fall = advance && strobe_edge && !strobe_line;
      ctrl.read_en    = advance && (op == OP_READ);
      ctrl.clear      = advance && (op == OP_CLEAR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         prev_a_ff     <= 1'b0;
         prev_b_ff     <= 1'b0;
         prev_s_ff     <= 1'b0;
         primed_ff     <= 1'b0;
         step_error_ff <= 1'b0;
      end else if (advance) begin
         step_error_ff <= is_sample && primed_ff && da && db;
         if (is_sample) begin
            count_ff  <= count_in;
            prev_a_ff <= line_a;
            prev_b_ff <= line_b;
            prev_s_ff <= strobe_line;
            primed_ff <= 1'b1;
         end
      end
   end

   // sign-extend or truncate the count to the port width
   generate
      if (COUNT_WIDTH >= OUT_WIDTH) begin : g_trunc
         assign position      = count_ff[OUT_WIDTH-1:0];
         assign capture_value = count_in[OUT_WIDTH-1:0];
      end else begin : g_sext
         assign position      = {{(OUT_WIDTH-COUNT_WIDTH){count_ff[COUNT_WIDTH-1]}},
                                 count_ff};
         assign capture_value = {{(OUT_WIDTH-COUNT_WIDTH){count_in[COUNT_WIDTH-1]}},
                                 count_in};
      end
   endgenerate

   assign step_error = step_error_ff;

endmodule

// File: design/qcec_capture.sv
// ----------------------------------------------------------------------------
// qcec_capture
// rising and falling capture tables with fill levels and lost flag
// ----------------------------------------------------------------------------
module qcec_capture import qcec_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  capture_ctrl_type            ctrl,
   input  logic [OUT_WIDTH-1:0]        capture_value,
   input  logic                        read_table,
   input  logic [INDEX_WIDTH-1:0]      read_index,
   output logic [ENTRIES_WIDTH-1:0]    rising_entries,
   output logic [ENTRIES_WIDTH-1:0]    falling_entries,
   output logic signed [OUT_WIDTH-1:0] read_data,
   output logic                        capture_lost
);

   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int FILL_W   = (CNT_BITS > ENTRIES_WIDTH) ? CNT_BITS : ENTRIES_WIDTH;
   localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(TABLE_DEPTH);

   logic [OUT_WIDTH-1:0] rise_mem [TABLE_DEPTH];
   logic [OUT_WIDTH-1:0] fall_mem [TABLE_DEPTH];

   logic [FILL_W-1:0]    rise_fill_ff, fall_fill_ff;
   logic                 lost_ff;
   logic [OUT_WIDTH-1:0] rise_rd_ff, fall_rd_ff;
   logic                 hit_ff, sel_ff;

   logic [FILL_W-1:0] index_ext;
   logic [ADDR_W-1:0] rd_addr;
   logic              rise_full, fall_full, hit;

   assign index_ext = FILL_W'(read_index);
   assign rd_addr   = index_ext[ADDR_W-1:0];
   assign rise_full = (rise_fill_ff >= DEPTH_FILL);
   assign fall_full = (fall_fill_ff >= DEPTH_FILL);
   // entries at or beyond the fill level read as zero
   assign hit = read_table ? (index_ext < fall_fill_ff) : (index_ext < rise_fill_ff);

   always_ff @(posedge clock) begin
      if (ctrl.store_rise && !rise_full) begin
         rise_mem[rise_fill_ff[ADDR_W-1:0]] <= capture_value;
      end
      if (ctrl.store_fall && !fall_full) begin
         fall_mem[fall_fill_ff[ADDR_W-1:0]] <= capture_value;
      end
      if (ctrl.read_en) begin
         rise_rd_ff <= rise_mem[rd_addr];
         fall_rd_ff <= fall_mem[rd_addr];
         sel_ff     <= read_table;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_fill_ff <= '0;
         fall_fill_ff <= '0;
         lost_ff      <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         // every item reloads the read flag, so only reads report data
         if (advance) begin
            hit_ff <= ctrl.read_en && hit;
         end
         if (ctrl.clear) begin
            rise_fill_ff <= '0;
            fall_fill_ff <= '0;
            lost_ff      <= 1'b0;
         end
         if (ctrl.store_rise) begin
            if (rise_full) begin
               lost_ff <= 1'b1;
            end else begin
               rise_fill_ff <= rise_fill_ff + FILL_W'(1);
            end
         end
         if (ctrl.store_fall) begin
            if (fall_full) begin
               lost_ff <= 1'b1;
            end else begin
               fall_fill_ff <= fall_fill_ff + FILL_W'(1);
            end
         end
      end
   end

   assign rising_entries  = rise_fill_ff[ENTRIES_WIDTH-1:0];
   assign falling_entries = fall_fill_ff[ENTRIES_WIDTH-1:0];
   assign read_data       = hit_ff ? (sel_ff ? fall_rd_ff : rise_rd_ff) : '0;
   assign capture_lost    = lost_ff;

endmodule

// File: design/quadrature_counter_with_edge_capture.sv
// ----------------------------------------------------------------------------
// quadrature_counter_with_edge_capture
// x4 quadrature position counter with strobe-edge position capture tables
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  req       in         req_valid / req_ready      op, lines, read select
//  rsp       out        rsp_valid / rsp_ready      position, fills, read data, flags
//  csr       in         csr_write_enable           capture_enable (1 bit)
//
//  one item per cycle sustained while rsp_ready stays high; rsp valid follows the req accept
//  through the input register, then the state/result registers
//  table reads come from a registered memory port loaded together with the result
//  reset clears count, previous levels, fill levels and flags; tables are not cleared
//  a stalled rsp holds the result and the input register; req_ready drops only
//  when both are full
//
module quadrature_counter_with_edge_capture import qcec_pkg::*; #(
   parameter int TABLE_DEPTH = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  logic                          req_line_a,
   input  logic                          req_line_b,
   input  logic                          req_strobe_line,
   input  logic                          req_read_table,
   input  logic [INDEX_WIDTH-1:0]        req_read_index,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [OUT_WIDTH-1:0]   rsp_position,
   output logic [ENTRIES_WIDTH-1:0]      rsp_rising_entries,
   output logic [ENTRIES_WIDTH-1:0]      rsp_falling_entries,
   output logic signed [OUT_WIDTH-1:0]   rsp_read_data,
   output logic                          rsp_capture_lost,
   output logic                          rsp_step_error,
   // configuration
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data
);

   // input register
   logic                   in_valid_ff;
   logic [1:0]             op_ff;
   logic                   line_a_ff, line_b_ff, strobe_ff;
   logic                   read_table_ff;
   logic [INDEX_WIDTH-1:0] read_index_ff;

   logic                   rsp_valid_ff;
   logic                   capture_enable_ff;
   logic                   advance;
   logic                   accept;
   logic [OUT_WIDTH-1:0]   capture_value;
   capture_ctrl_type       ctrl;

   // the state registers double as the result register: they only move on advance
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         capture_enable_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            capture_enable_ff <= csr_write_data;
         end
      end
   end

   // payload of the input register
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= req_op;
         line_a_ff     <= req_line_a;
         line_b_ff     <= req_line_b;
         strobe_ff     <= req_strobe_line;
         read_table_ff <= req_read_table;
         read_index_ff <= req_read_index;
      end
   end

   // count, edge detect and per-item commands
   qcec_track #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_track (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .op             (op_ff),
      .line_a         (line_a_ff),
      .line_b         (line_b_ff),
      .strobe_line    (strobe_ff),
      .capture_enable (capture_enable_ff),
      .position       (rsp_position),
      .capture_value  (capture_value),
      .step_error     (rsp_step_error),
      .ctrl           (ctrl)
   );

   // capture tables, fill levels, lost flag and table read
   qcec_capture #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_capture (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .ctrl            (ctrl),
      .capture_value   (capture_value),
      .read_table      (read_table_ff),
      .read_index      (read_index_ff),
      .rising_entries  (rsp_rising_entries),
      .falling_entries (rsp_falling_entries),
      .read_data       (rsp_read_data),
      .capture_lost    (rsp_capture_lost)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule
